// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHK_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("check failed");

// Implication checked at every clock edge outside reset.
`define CHK_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

// ===== sv/h2r_pkg.sv =====
package h2r_pkg;

    // LEDs on the strip; indexes at or above this get index_ok low
    localparam int unsigned LED_COUNT = 64;

    // Fixed-point scale: 960 hue steps per sector, 255 for full intensity
    localparam int unsigned SECTOR_SPAN   = 960;
    localparam int unsigned FULL_SCALE    = 255;
    localparam int unsigned SCALE_PRODUCT = FULL_SCALE * SECTOR_SPAN;
    localparam int unsigned SECTOR_COUNT  = 6;

    // Division by 244800 = 64 * 3825: shift by 6, then reciprocal multiply.
    // z * RECIP_3825 >> 32 is exact for z below 2^32 / 2804.
    localparam int unsigned PRE_SHIFT   = 6;
    localparam int unsigned RECIP_SHIFT = 32;
    localparam logic [20:0] RECIP_3825  = 21'd1122868;

    // Clock edges from an accepted transaction to the result strobe
    localparam int unsigned LATENCY = 5;

    // Hue sector, 60 degrees each
    typedef enum logic [2:0] {
        SECT_RED_YELLOW,
        SECT_YELLOW_GREEN,
        SECT_GREEN_CYAN,
        SECT_CYAN_BLUE,
        SECT_BLUE_MAGENTA,
        SECT_MAGENTA_RED
    } sector_t;

    typedef struct packed {
        logic [15:0] pixel_index;
        logic [12:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  brightness;
    } pixel_in_t;

    typedef struct packed {
        logic [15:0] pixel_tag;
        logic        index_ok;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } pixel_out_t;

endpackage

// ===== sv/hsv_to_rgb_converter.sv =====
// Channel   Ports                  Transaction
// --------  ---------------------  ----------------------------------------
// input     start, busy, item      taken at a clock edge with start && !busy
// output    done, result           shown one cycle, taken at the edge ending it
//
// Five-stage pipeline: sector split, s*frac products, v*x products,
// constant division, sector mux. One pixel per clock; the products of
// stages 2 and 3 set the depth.
// busy stays low: the pipeline never holds, since the receiver takes every
// result. Reset (rst_n, async) clears the valid bits only; no clearing pass.
module hsv_to_rgb_converter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  h2r_pkg::pixel_in_t    item,
    output logic                  done,
    output h2r_pkg::pixel_out_t   result
);
    import h2r_pkg::*;

    // Stage 1: sector and fraction of the hue
    logic        vld1_reg;
    sector_t     sect1_reg;
    logic [9:0]  frac1_reg;
    logic [7:0]  sat1_reg;
    logic [7:0]  bri1_reg;
    logic [15:0] tag1_reg;
    logic        ok1_reg;

    // Stage 2: saturation products
    logic        vld2_reg;
    sector_t     sect2_reg;
    logic [17:0] sf2_reg;
    logic [17:0] sg2_reg;
    logic [15:0] pp2_reg;
    logic [7:0]  bri2_reg;
    logic [15:0] tag2_reg;
    logic        ok2_reg;

    // Stage 3: brightness products, p done
    logic        vld3_reg;
    sector_t     sect3_reg;
    logic [25:0] yq3_reg;
    logic [25:0] yt3_reg;
    logic [7:0]  p3_reg;
    logic [7:0]  bri3_reg;
    logic [15:0] tag3_reg;
    logic        ok3_reg;

    // Stage 4: q and t after the constant division
    logic        vld4_reg;
    sector_t     sect4_reg;
    logic [7:0]  q4_reg;
    logic [7:0]  t4_reg;
    logic [7:0]  p4_reg;
    logic [7:0]  bri4_reg;
    logic [15:0] tag4_reg;
    logic        ok4_reg;

    // Output register
    logic        done_reg;
    pixel_out_t  result_reg;
    pixel_out_t  result_next;

    logic        accept;
    logic [3:0]  quo1;
    logic [3:0]  sect_num1;
    logic [12:0] frac_full1;
    sector_t     sect1_next;
    logic [16:0] p_sum3;
    logic [25:0] yq3_next;
    logic [25:0] yt3_next;
    logic [19:0] zq4;
    logic [19:0] zt4;
    logic [40:0] mq4;
    logic [40:0] mt4;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Hue / 960 by constant compares, at most eight steps
    always_comb
    begin
        quo1 = 4'd0;
        for (int k = 1; k <= 8; k++)
        begin
            if (item.hue >= 13'(k * SECTOR_SPAN))
            begin
                quo1 = 4'(k);
            end
        end
        frac_full1 = item.hue - 13'(quo1 * 4'd15 * 13'd64);
        sect_num1  = (quo1 >= 4'(SECTOR_COUNT)) ? quo1 - 4'(SECTOR_COUNT) : quo1;
        sect1_next = sector_t'(sect_num1[2:0]);
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= accept;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            done_reg <= vld4_reg;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sect1_reg <= sect1_next;
            frac1_reg <= frac_full1[9:0];
            sat1_reg  <= item.saturation;
            bri1_reg  <= item.brightness;
            tag1_reg  <= item.pixel_index;
            ok1_reg   <= (item.pixel_index < 16'(LED_COUNT));
        end
    end

    // Stage 2: s*frac, s*(960-frac), v*(255-s)
    always_ff @(posedge clk)
    begin
        if (vld1_reg)
        begin
            sect2_reg <= sect1_reg;
            sf2_reg   <= 18'(sat1_reg) * 18'(frac1_reg);
            sg2_reg   <= 18'(sat1_reg) * 18'(10'(SECTOR_SPAN) - frac1_reg);
            pp2_reg   <= 16'(bri1_reg) * 16'(8'(FULL_SCALE) - sat1_reg);
            bri2_reg  <= bri1_reg;
            tag2_reg  <= tag1_reg;
            ok2_reg   <= ok1_reg;
        end
    end

    // Stage 3: v*(244800-x) and p = floor(x/255) for x below 65280
    assign yq3_next = 26'(bri2_reg) * 26'(18'(SCALE_PRODUCT) - sf2_reg);
    assign yt3_next = 26'(bri2_reg) * 26'(18'(SCALE_PRODUCT) - sg2_reg);
    assign p_sum3   = 17'(pp2_reg) + 17'(pp2_reg[15:8]) + 17'd1;

    always_ff @(posedge clk)
    begin
        if (vld2_reg)
        begin
            sect3_reg <= sect2_reg;
            yq3_reg   <= yq3_next;
            yt3_reg   <= yt3_next;
            p3_reg    <= p_sum3[15:8];
            bri3_reg  <= bri2_reg;
            tag3_reg  <= tag2_reg;
            ok3_reg   <= ok2_reg;
        end
    end

    // Stage 4: divide by 244800 via shift and reciprocal of 3825
    assign zq4 = yq3_reg[25:PRE_SHIFT];
    assign zt4 = yt3_reg[25:PRE_SHIFT];
    assign mq4 = 41'(zq4) * 41'(RECIP_3825);
    assign mt4 = 41'(zt4) * 41'(RECIP_3825);

    always_ff @(posedge clk)
    begin
        if (vld3_reg)
        begin
            sect4_reg <= sect3_reg;
            q4_reg    <= mq4[RECIP_SHIFT +: 8];
            t4_reg    <= mt4[RECIP_SHIFT +: 8];
            p4_reg    <= p3_reg;
            bri4_reg  <= bri3_reg;
            tag4_reg  <= tag3_reg;
            ok4_reg   <= ok3_reg;
        end
    end

    // Stage 5: six-sector channel assignment
    always_comb
    begin
        result_next.pixel_tag = tag4_reg;
        result_next.index_ok  = ok4_reg;
        case (sect4_reg)
            SECT_RED_YELLOW:
            begin
                result_next.red   = bri4_reg;
                result_next.green = t4_reg;
                result_next.blue  = p4_reg;
            end
            SECT_YELLOW_GREEN:
            begin
                result_next.red   = q4_reg;
                result_next.green = bri4_reg;
                result_next.blue  = p4_reg;
            end
            SECT_GREEN_CYAN:
            begin
                result_next.red   = p4_reg;
                result_next.green = bri4_reg;
                result_next.blue  = t4_reg;
            end
            SECT_CYAN_BLUE:
            begin
                result_next.red   = p4_reg;
                result_next.green = q4_reg;
                result_next.blue  = bri4_reg;
            end
            SECT_BLUE_MAGENTA:
            begin
                result_next.red   = t4_reg;
                result_next.green = p4_reg;
                result_next.blue  = bri4_reg;
            end
            default:
            begin
                result_next.red   = bri4_reg;
                result_next.green = p4_reg;
                result_next.blue  = q4_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (vld4_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== sv/h2r_checker.sv =====
`include "assert_macros.svh"

module h2r_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input h2r_pkg::pixel_in_t   item,
    input logic                 done,
    input h2r_pkg::pixel_out_t  result
);
    import h2r_pkg::*;

    localparam int unsigned WARM_W = $clog2(LATENCY + 1);

    // Cycles since reset release, saturating at the pipeline latency
    logic [WARM_W-1:0] warm_reg;
    logic              warm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_reg <= '0;
        end
        else if (warm_reg != WARM_W'(LATENCY))
        begin
            warm_reg <= warm_reg + 1'b1;
        end
    end

    assign warm = (warm_reg == WARM_W'(LATENCY));

    // Every taken transaction gives a strobe after the fixed latency
    `CHK_IMPLY(a_result_follows, clk, rst_n, warm && $past(start && !busy, LATENCY), done)
    // No strobe without a transaction taken that many cycles before
    `CHK_IMPLY(a_no_spurious, clk, rst_n, done, $past(start && !busy, LATENCY))
    // Pixel tag travels with its colour
    `CHK_IMPLY(a_tag_follows, clk, rst_n, done,
        result.pixel_tag == $past(item.pixel_index, LATENCY))
    // Range flag matches the tag it is shown with
    `CHK_IMPLY(a_index_flag, clk, rst_n, done,
        result.index_ok == (result.pixel_tag < 16'(LED_COUNT)))

endmodule

bind hsv_to_rgb_converter h2r_checker u_h2r_checker (.*);

// ===== bench/hsv_to_rgb_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the converter, predicts each pixel and compares.
module hsv_to_rgb_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  h2r_pkg::pixel_in_t   item,
    input  logic                 done,
    input  h2r_pkg::pixel_out_t  result,
    output int                   errors,
    output int                   outstanding,
    output int                   pixels_checked
);
    import h2r_pkg::*;

    // Predicted colors, oldest first
    pixel_out_t rgb_expected[$];

    // Fixed-point HSV to RGB, six-sector assignment
    function automatic pixel_out_t compute_rgb(pixel_in_t px);
        int unsigned hue_v;
        int unsigned sat;
        int unsigned val;
        int unsigned frac;
        int unsigned p_lvl;
        int unsigned q_lvl;
        int unsigned t_lvl;
        sector_t     sect;
        pixel_out_t  rgb;
        hue_v = px.hue;
        sat   = px.saturation;
        val   = px.brightness;
        // sector wraps modulo 6 without reducing the hue first
        sect  = sector_t'((hue_v / SECTOR_SPAN) % SECTOR_COUNT);
        frac  = hue_v % SECTOR_SPAN;
        p_lvl = (val * (FULL_SCALE - sat)) / FULL_SCALE;
        q_lvl = (val * (SCALE_PRODUCT - sat * frac)) / SCALE_PRODUCT;
        t_lvl = (val * (SCALE_PRODUCT - sat * (SECTOR_SPAN - frac))) / SCALE_PRODUCT;
        rgb.pixel_tag = px.pixel_index;
        rgb.index_ok  = (px.pixel_index < LED_COUNT);
        case (sect)
            SECT_RED_YELLOW:
            begin
                rgb.red = 8'(val);   rgb.green = 8'(t_lvl); rgb.blue = 8'(p_lvl);
            end
            SECT_YELLOW_GREEN:
            begin
                rgb.red = 8'(q_lvl); rgb.green = 8'(val);   rgb.blue = 8'(p_lvl);
            end
            SECT_GREEN_CYAN:
            begin
                rgb.red = 8'(p_lvl); rgb.green = 8'(val);   rgb.blue = 8'(t_lvl);
            end
            SECT_CYAN_BLUE:
            begin
                rgb.red = 8'(p_lvl); rgb.green = 8'(q_lvl); rgb.blue = 8'(val);
            end
            SECT_BLUE_MAGENTA:
            begin
                rgb.red = 8'(t_lvl); rgb.green = 8'(p_lvl); rgb.blue = 8'(val);
            end
            default:
            begin
                rgb.red = 8'(val);   rgb.green = 8'(p_lvl); rgb.blue = 8'(q_lvl);
            end
        endcase
        return rgb;
    endfunction

    // Record accepted transactions, check each strobed result
    always @(posedge clk or negedge rst_n)
    begin
        pixel_out_t want;
        if (!rst_n)
        begin
            rgb_expected.delete();
            errors         <= 0;
            pixels_checked <= 0;
            outstanding    <= 0;
        end
        else
        begin
            if (start && !busy)
                rgb_expected.push_back(compute_rgb(item));
            if (done)
            begin
                if (rgb_expected.size() == 0)
                begin
                    errors <= errors + 1;
                    $display("%0t: unexpected result, expected none, actual %h/%b/%h/%h/%h",
                             $time, result.pixel_tag, result.index_ok,
                             result.red, result.green, result.blue);
                end
                else
                begin
                    want = rgb_expected.pop_front();
                    pixels_checked <= pixels_checked + 1;
                    if (result.pixel_tag !== want.pixel_tag || result.index_ok !== want.index_ok
                        || result.red !== want.red || result.green !== want.green
                        || result.blue !== want.blue)
                    begin
                        errors <= errors + 1;
                        $display("%0t: mismatch, expected %h/%b/%h/%h/%h, actual %h/%b/%h/%h/%h",
                                 $time, want.pixel_tag, want.index_ok,
                                 want.red, want.green, want.blue,
                                 result.pixel_tag, result.index_ok,
                                 result.red, result.green, result.blue);
                    end
                end
            end
            outstanding <= rgb_expected.size();
        end
    end

endmodule

// ===== bench/tb_hsv_to_rgb_converter.sv =====
`timescale 1ns / 100ps

module tb_hsv_to_rgb_converter;
    import h2r_pkg::*;

    localparam int RANDOM_PIXELS = 1400;
    localparam int QUIET_TAIL    = 200;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    pixel_in_t  item;
    logic       done;
    pixel_out_t result;
    int         errors;
    int         outstanding;
    int         pixels_checked;
    int         directed_sent;
    int         random_sent;

    hsv_to_rgb_converter DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    hsv_to_rgb_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .item           (item),
        .done           (done),
        .result         (result),
        .errors         (errors),
        .outstanding    (outstanding),
        .pixels_checked (pixels_checked)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog
    initial
    begin
        #1ms;
        $display("Timeout with %0d pixels still outstanding", outstanding);
        $display("CHECK FAILED");
        $finish;
    end

    // Drive one pixel transaction and wait until it is taken
    task automatic send_pixel(input logic [15:0] idx, input logic [12:0] hue_v,
                              input logic [7:0] sat, input logic [7:0] val);
        @(negedge clk);
        start <= 1'b1;
        item  <= '{pixel_index: idx, hue: hue_v, saturation: sat, brightness: val};
        do
            @(posedge clk);
        while (busy);
    endtask

    // Hold start low for a number of cycles, with noise on the payload
    task automatic idle_cycles(input int n);
        @(negedge clk);
        start <= 1'b0;
        item  <= pixel_in_t'({$urandom, $urandom});
        repeat (n - 1) @(negedge clk);
    endtask

    // Random pixel, biased toward extremes, in-range indexes and the nominal hue range
    task automatic send_random_pixel();
        logic [15:0] idx;
        logic [12:0] hue_v;
        logic [7:0]  sat;
        logic [7:0]  val;
        case ($urandom_range(0, 3))
            0:       idx = 16'($urandom_range(0, LED_COUNT - 1));
            1:       idx = 16'($urandom_range(LED_COUNT - 3, LED_COUNT + 3));
            default: idx = 16'($urandom);
        endcase
        if ($urandom_range(0, 7) == 0)
            hue_v = 13'($urandom_range(5761, 8191));
        else if ($urandom_range(0, 7) == 0)
            hue_v = 13'(SECTOR_SPAN * $urandom_range(0, 6) + $urandom_range(0, 2) - 1);
        else
            hue_v = 13'($urandom_range(0, 5760));
        case ($urandom_range(0, 5))
            0:       sat = 8'd0;
            1:       sat = 8'd255;
            default: sat = 8'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       val = 8'd0;
            1:       val = 8'd255;
            default: val = 8'($urandom);
        endcase
        send_pixel(idx, hue_v, sat, val);
    endtask

    initial
    begin
        int  wait_cnt;
        bit  idle_on;
        rst_n         = 1'b0;
        start         = 1'b0;
        item          = '0;
        directed_sent = 0;
        random_sent   = 0;
        idle_on       = 1'b1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: sector edges, full-turn hue, wrapped hues, extremes, index limits
        send_pixel(16'd0,     13'd0,    8'd255, 8'd255);
        send_pixel(16'd1,     13'd959,  8'd255, 8'd255);
        send_pixel(16'd2,     13'd960,  8'd255, 8'd255);
        send_pixel(16'd3,     13'd1440, 8'd255, 8'd255);
        send_pixel(16'd4,     13'd1920, 8'd200, 8'd255);
        send_pixel(16'd5,     13'd2880, 8'd255, 8'd128);
        send_pixel(16'd6,     13'd3840, 8'd255, 8'd255);
        send_pixel(16'd7,     13'd4800, 8'd100, 8'd255);
        send_pixel(16'd8,     13'd5759, 8'd255, 8'd255);
        send_pixel(16'd9,     13'd5760, 8'd255, 8'd255);
        send_pixel(16'd10,    13'd6720, 8'd255, 8'd255);
        send_pixel(16'd11,    13'd8191, 8'd255, 8'd255);
        send_pixel(16'd12,    13'd3000, 8'd0,   8'd255);
        send_pixel(16'd13,    13'd3000, 8'd255, 8'd0);
        send_pixel(16'd14,    13'd479,  8'd0,   8'd0);
        send_pixel(16'd63,    13'd2500, 8'd128, 8'd77);
        send_pixel(16'd64,    13'd4000, 8'd255, 8'd255);
        send_pixel(16'hFFFF,  13'd5000, 8'd255, 8'd255);
        send_pixel(16'h8000,  13'h1555, 8'hAA,  8'h55);
        send_pixel(16'h7FFF,  13'h0AAA, 8'h55,  8'hAA);
        directed_sent = 20;
        idle_cycles(3);

        // Random pixels with idle bursts that switch on and off in stretches
        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            if (i % 64 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if (idle_on && i < RANDOM_PIXELS - QUIET_TAIL && $urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 5));
            send_random_pixel();
            random_sent++;
        end
        idle_cycles(1);

        // Drain the pipeline
        wait_cnt = 0;
        while (outstanding != 0 && wait_cnt < 1000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (LATENCY + 5) @(posedge clk);

        $display("Converted %0d pixels: %0d directed, %0d random over all six sectors,",
                 pixels_checked, directed_sent, random_sent);
        $display("wrapped hues, full and zero saturation and value, indexes around the LED count");
        if (errors == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/h2r_pkg.sv
sv/hsv_to_rgb_converter.sv
sv/h2r_checker.sv
bench/hsv_to_rgb_checker.sv
bench/tb_hsv_to_rgb_converter.sv
